### rtl/core/vpwb_pkg.sv
// Package for the Verlet particle block: widths, codes, reset values, config struct.
// Used by the interfaces and by every module under rtl/core.
package vpwb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_BITS     = 16;
    localparam int POS_W         = 32;
    localparam int SUM_W         = POS_W + 2;

    localparam int RADIUS_W  = 27;
    localparam int ARENA_W   = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 29;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ACCEL = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

    localparam logic [RADIUS_W-1:0]  RADIUS_RST   = 27'd655360;
    localparam logic [COEF_BITS-1:0] FRICTION_RST = 16'd65470;
    localparam logic [COEF_BITS-1:0] BOUNCE_RST   = 16'd32768;
    localparam logic [ARENA_W-1:0]   WIDTH_RST    = 29'd83886080;
    localparam logic [ARENA_W-1:0]   HEIGHT_RST   = 29'd47185920;

    typedef enum logic [1:0] {
        HIT_NONE = 2'd0,
        HIT_LOW  = 2'd1,
        HIT_HIGH = 2'd2
    } t_hit;

    typedef struct packed {
        logic [RADIUS_W-1:0]  radius;
        logic [COEF_BITS-1:0] friction;
        logic [COEF_BITS-1:0] bounce;
        logic [ARENA_W-1:0]   width;
        logic [ARENA_W-1:0]   height;
    } t_cfg;

    // Clip a widened sum back into the signed 32-bit range.
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(34'sh07FFFFFFF);
        lo = -hi - SUM_W'(34'sd1);
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

### rtl/core/vpwb_in_if.sv
// Input channel of the Verlet particle block: valid/ready plus one command item.
// Depends on vpwb_pkg.
interface vpwb_in_if import vpwb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [POS_W-1:0] load_x;
    logic signed [POS_W-1:0] load_y;
    logic signed [POS_W-1:0] accel_x;
    logic signed [POS_W-1:0] accel_y;
    logic [COEF_BITS-1:0]    time_step;

    modport source (output valid, kind, load_x, load_y, accel_x, accel_y, time_step,
                    input ready);
    modport sink   (input valid, kind, load_x, load_y, accel_x, accel_y, time_step,
                    output ready);
endinterface

### rtl/core/vpwb_out_if.sv
// Output channel of the Verlet particle block: valid/ready plus position and wall hits.
// Depends on vpwb_pkg.
interface vpwb_out_if import vpwb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [1:0]              hit_x;
    logic [1:0]              hit_y;

    modport source (output valid, pos_x, pos_y, hit_x, hit_y, input ready);
    modport sink   (input valid, pos_x, pos_y, hit_x, hit_y, output ready);
endinterface

### rtl/core/vpwb_cfg.sv
// Configuration registers of the Verlet particle block (radius, coefficients, arena).
// Depends on vpwb_pkg.
module vpwb_cfg import vpwb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius   <= RADIUS_RST;
            r_cfg.friction <= FRICTION_RST;
            r_cfg.bounce   <= BOUNCE_RST;
            r_cfg.width    <= WIDTH_RST;
            r_cfg.height   <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:   r_cfg.radius   <= i_cfg_data[RADIUS_W-1:0];
                REG_FRICTION: r_cfg.friction <= i_cfg_data[COEF_BITS-1:0];
                REG_BOUNCE:   r_cfg.bounce   <= i_cfg_data[COEF_BITS-1:0];
                REG_WIDTH:    r_cfg.width    <= i_cfg_data[ARENA_W-1:0];
                REG_HEIGHT:   r_cfg.height   <= i_cfg_data[ARENA_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/vpwb_mul.sv
// Shared multiplier: signed 32-bit by unsigned Q0.16, floored back to 32 bits, registered.
// Depends on vpwb_pkg.
module vpwb_mul import vpwb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [POS_W-1:0] i_a,
    input  logic [COEF_BITS-1:0]    i_b,
    output logic signed [POS_W-1:0] o_prod
);

    localparam int PROD_W = POS_W + COEF_BITS + 1;

    logic signed [PROD_W-1:0] w_full;
    logic signed [POS_W-1:0]  r_prod;

    assign w_full = PROD_W'(i_a) * PROD_W'($signed({1'b0, i_b}));

    // Arithmetic shift of the exact product is the floor toward minus infinity.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[POS_W+COEF_BITS-1:COEF_BITS];
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/verlet_particle_wall_bounce.sv
// Verlet particle block, top level: sequencer, particle state, output register.
// Depends on vpwb_pkg, vpwb_in_if, vpwb_out_if, vpwb_cfg and vpwb_mul.
//
// Usage: i_in carries command items (load position, add acceleration, integration
// step); o_out returns one item per command with the current position and the
// wall hit codes of that command (zero for all but a step). The config port
// writes one register per cycle with i_cfg_we; write it only while the block idles.
// Sequencing: a load, accel or unused-kind item goes from S_IDLE to S_DONE, which
// loads its result into the output register; the next item is taken in S_IDLE.
// A step item runs seven slots on one shared 32x16 multiplier (dt*dt, two friction
// products, two acceleration products, two bounce kicks) with the sums, clamps and
// kick updates riding alongside, then passes S_CY, S_PY and S_DONE; a new item is
// taken only once the block is back in S_IDLE.
// i_in.ready is high only while no item is in progress. A finished result waits in
// its own state until the output register is free, so a stalled receiver holds
// the block; the register itself stays valid until taken.
// Reset (synchronous, active low) clears position, previous position, summed
// acceleration and the output valid, and loads the register defaults.
module verlet_particle_wall_bounce import vpwb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vpwb_in_if.sink              i_in,
    vpwb_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic signed [SUM_W-1:0] THREE = SUM_W'(3) <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DT, S_VX, S_VY, S_AX, S_AY, S_KX, S_KY, S_CY, S_PY, S_DONE
    } t_state;

    t_state r_state;
    t_cfg   w_cfg;

    logic signed [POS_W-1:0] r_cur_x, r_cur_y, r_prev_x, r_prev_y, r_acc_x, r_acc_y;
    logic signed [POS_W-1:0] r_dx, r_dy, r_vx, r_vy, r_ax, r_ay, r_kx;
    logic [COEF_BITS-1:0]    r_dt, r_dt2;
    t_hit                    r_hit_x, r_hit_y;

    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos_x, r_out_pos_y;
    t_hit                    r_out_hit_x, r_out_hit_y;

    logic                    w_mul_en;
    logic signed [POS_W-1:0] w_mul_a, w_mul_b_ext, w_prod;
    logic [COEF_BITS-1:0]    w_mul_b;
    logic                    w_accept;

    logic signed [SUM_W-1:0] w_rad, w_lim_x, w_lim_y, w_px, w_py;
    logic                    w_hi_x, w_lo_x, w_hi_y, w_lo_y;

    vpwb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    vpwb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_mul_b_ext = $signed(POS_W'(r_dt));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            S_DT: begin
                w_mul_a = w_mul_b_ext;
                w_mul_b = r_dt;
            end
            S_VX: begin
                w_mul_a = r_dx;
                w_mul_b = w_cfg.friction;
            end
            S_VY: begin
                w_mul_a = r_dy;
                w_mul_b = w_cfg.friction;
            end
            S_AX: begin
                w_mul_a = r_acc_x;
                w_mul_b = r_dt2;
            end
            S_AY: begin
                w_mul_a = r_acc_y;
                w_mul_b = r_dt2;
            end
            S_KX: begin
                w_mul_a = r_vx;
                w_mul_b = w_cfg.bounce;
            end
            S_KY: begin
                w_mul_a = r_vy;
                w_mul_b = w_cfg.bounce;
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    // Wall tests on the current position; the high wall wins over the low wall.
    assign w_rad   = $signed(SUM_W'(w_cfg.radius));
    assign w_lim_x = $signed(SUM_W'(w_cfg.width));
    assign w_lim_y = $signed(SUM_W'(w_cfg.height));
    assign w_px    = SUM_W'(r_cur_x);
    assign w_py    = SUM_W'(r_cur_y);
    assign w_hi_x  = (w_px + w_rad) > w_lim_x;
    assign w_lo_x  = (w_px - w_rad) < 0;
    assign w_hi_y  = (w_py + w_rad) > w_lim_y;
    assign w_lo_y  = (w_py - w_rad) < 0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_hit_x     <= HIT_NONE;
            r_hit_y     <= HIT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output item once taken, unless a new one is loaded this cycle
            if (o_out.valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_hit_x <= HIT_NONE;
                    r_hit_y <= HIT_NONE;
                    r_dt    <= i_in.time_step;
                    if (w_accept) begin
                        r_state <= (i_in.kind == KIND_STEP) ? S_DT : S_DONE;
                        case (i_in.kind)
                            KIND_LOAD: begin
                                r_cur_x  <= i_in.load_x;
                                r_cur_y  <= i_in.load_y;
                                r_prev_x <= sat32(SUM_W'(i_in.load_x) + THREE);
                                r_prev_y <= sat32(SUM_W'(i_in.load_y) + THREE);
                                r_acc_x  <= '0;
                                r_acc_y  <= '0;
                            end
                            KIND_ACCEL: begin
                                r_acc_x <= sat32(SUM_W'(r_acc_x) + SUM_W'(i_in.accel_x));
                                r_acc_y <= sat32(SUM_W'(r_acc_y) + SUM_W'(i_in.accel_y));
                            end
                            default: ;
                        endcase
                    end
                end
                S_DT: begin
                    r_dx    <= sat32(SUM_W'(r_cur_x) - SUM_W'(r_prev_x));
                    r_dy    <= sat32(SUM_W'(r_cur_y) - SUM_W'(r_prev_y));
                    r_state <= S_VX;
                end
                S_VX: begin
                    r_dt2   <= w_prod[COEF_BITS-1:0];
                    r_state <= S_VY;
                end
                S_VY: begin
                    r_vx    <= w_prod;
                    r_state <= S_AX;
                end
                S_AX: begin
                    r_vy    <= w_prod;
                    r_state <= S_AY;
                end
                S_AY: begin
                    r_ax    <= w_prod;
                    r_state <= S_KX;
                end
                S_KX: begin
                    r_ay     <= w_prod;
                    r_prev_x <= r_cur_x;
                    r_cur_x  <= sat32(SUM_W'(r_cur_x) + SUM_W'(r_vx) + SUM_W'(r_ax));
                    r_acc_x  <= '0;
                    r_acc_y  <= '0;
                    r_state  <= S_KY;
                end
                S_KY: begin
                    r_kx     <= w_prod;
                    r_prev_y <= r_cur_y;
                    r_cur_y  <= sat32(SUM_W'(r_cur_y) + SUM_W'(r_vy) + SUM_W'(r_ay));
                    if (w_hi_x) begin
                        r_cur_x <= sat32(w_lim_x - w_rad);
                        r_hit_x <= HIT_HIGH;
                    end else if (w_lo_x) begin
                        r_cur_x <= sat32(w_rad);
                        r_hit_x <= HIT_LOW;
                    end
                    r_state  <= S_CY;
                end
                S_CY: begin
                    if (r_hit_x != HIT_NONE) begin
                        r_prev_x <= sat32(w_px + SUM_W'(r_kx));
                    end
                    if (w_hi_y) begin
                        r_cur_y <= sat32(w_lim_y - w_rad);
                        r_hit_y <= HIT_HIGH;
                    end else if (w_lo_y) begin
                        r_cur_y <= sat32(w_rad);
                        r_hit_y <= HIT_LOW;
                    end
                    r_state <= S_PY;
                end
                S_PY: begin
                    // Kick for y is still held in the multiplier output.
                    if (r_hit_y != HIT_NONE) begin
                        r_prev_y <= sat32(w_py + SUM_W'(w_prod));
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pos_x <= r_cur_x;
                        r_out_pos_y <= r_cur_y;
                        r_out_hit_x <= r_hit_x;
                        r_out_hit_y <= r_hit_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.pos_x = r_out_pos_x;
    assign o_out.pos_y = r_out_pos_y;
    assign o_out.hit_x = r_out_hit_x;
    assign o_out.hit_y = r_out_hit_y;

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_out_valid || o_out.ready) |=> r_out_valid)
        else $error("finished item not loaded into output register");

    a_step_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.kind == KIND_STEP) |=> !i_in.ready ##1 !i_in.ready)
        else $error("input taken while a step is in progress");

    a_step_clears_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KX) |=> (r_acc_x == '0) && (r_acc_y == '0))
        else $error("acceleration not cleared by a step");

    a_hit_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.kind != KIND_STEP) |=>
        (r_hit_x == HIT_NONE) && (r_hit_y == HIT_NONE))
        else $error("wall hit reported for a non-step item");

endmodule

### tb/tb_verlet_particle_wall_bounce.sv
`timescale 1ns / 1ps
// Self-checking bench for verlet_particle_wall_bounce: directed table, then random scenes.
// Depends on vpwb_pkg, vpwb_in_if, vpwb_out_if and the block itself.
module tb_verlet_particle_wall_bounce;
    import vpwb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = 27'd67108864;
    localparam logic [ARENA_W-1:0] ARENA_MAX = 29'd268435456;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] load_x;
        logic signed [POS_W-1:0] load_y;
        logic signed [POS_W-1:0] accel_x;
        logic signed [POS_W-1:0] accel_y;
        logic [COEF_BITS-1:0]    time_step;
    } t_particle_cmd;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        t_hit                    hit_x;
        t_hit                    hit_y;
    } t_particle_pos;

    typedef struct packed {
        t_particle_cmd cmd;
        logic          known;
        t_particle_pos pos;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    vpwb_in_if  cmd_if ();
    vpwb_out_if res_if ();

    verlet_particle_wall_bounce u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // particle state and register copy for the predictor
    longint part_x, part_y, trail_x, trail_y, accel_sum_x, accel_sum_y;
    t_cfg   arena_cfg;

    t_particle_pos expected_pos_q[$];
    t_dir_row      dir_rows[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    logic          hold_off_req;
    logic          hold_done;
    int            hold_left;
    int            error_count = 0;
    int            result_idx = 0;
    int            quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic longint clip32(input longint v);
        if (v > S32_HI) begin
            return S32_HI;
        end else if (v < S32_LO) begin
            return S32_LO;
        end
        return v;
    endfunction

    task automatic clamp_to_walls(inout longint pos, inout longint trail, input longint vel,
                                  input longint wall, output t_hit hit);
        longint rad;
        longint kick;
        rad  = longint'(arena_cfg.radius);
        kick = (vel * longint'(arena_cfg.bounce)) >>> COEF_BITS;
        hit  = HIT_NONE;
        // right/bottom wall wins when both would trip
        if (pos + rad > wall) begin
            pos   = clip32(wall - rad);
            trail = clip32(pos + kick);
            hit   = HIT_HIGH;
        end else if (pos - rad < 0) begin
            pos   = clip32(rad);
            trail = clip32(pos + kick);
            hit   = HIT_LOW;
        end
    endtask

    task automatic advance_particle(input t_particle_cmd c, output t_particle_pos r);
        longint three;
        longint dt2;
        longint vx, vy, ax, ay;
        t_hit   hx, hy;
        three = longint'(3) <<< FRAC_BITS_DEF;
        hx = HIT_NONE;
        hy = HIT_NONE;
        case (c.kind)
            KIND_LOAD: begin
                part_x      = longint'(c.load_x);
                part_y      = longint'(c.load_y);
                trail_x     = clip32(part_x + three);
                trail_y     = clip32(part_y + three);
                accel_sum_x = 0;
                accel_sum_y = 0;
            end
            KIND_ACCEL: begin
                accel_sum_x = clip32(accel_sum_x + longint'(c.accel_x));
                accel_sum_y = clip32(accel_sum_y + longint'(c.accel_y));
            end
            KIND_STEP: begin
                dt2 = (longint'(c.time_step) * longint'(c.time_step)) >>> COEF_BITS;
                vx  = (clip32(part_x - trail_x) * longint'(arena_cfg.friction)) >>> COEF_BITS;
                vy  = (clip32(part_y - trail_y) * longint'(arena_cfg.friction)) >>> COEF_BITS;
                ax  = (accel_sum_x * dt2) >>> COEF_BITS;
                ay  = (accel_sum_y * dt2) >>> COEF_BITS;
                trail_x     = part_x;
                trail_y     = part_y;
                part_x      = clip32(part_x + vx + ax);
                part_y      = clip32(part_y + vy + ay);
                accel_sum_x = 0;
                accel_sum_y = 0;
                clamp_to_walls(part_x, trail_x, vx, longint'(arena_cfg.width), hx);
                clamp_to_walls(part_y, trail_y, vy, longint'(arena_cfg.height), hy);
            end
            default: begin
            end
        endcase
        r.pos_x = part_x[POS_W-1:0];
        r.pos_y = part_y[POS_W-1:0];
        r.hit_x = hx;
        r.hit_y = hy;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: result %0d %s: expected %h, got %h", $time, result_idx, field, want, got);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg cfg);
        write_reg(REG_RADIUS, CFG_DAT_W'(cfg.radius));
        write_reg(REG_FRICTION, CFG_DAT_W'(cfg.friction));
        write_reg(REG_BOUNCE, CFG_DAT_W'(cfg.bounce));
        write_reg(REG_WIDTH, CFG_DAT_W'(cfg.width));
        write_reg(REG_HEIGHT, CFG_DAT_W'(cfg.height));
        i_cfg_we  <= 1'b0;
        arena_cfg  = cfg;
    endtask

    task automatic drive_cmd(input t_particle_cmd c, input logic known,
                             input t_particle_pos known_pos);
        t_particle_pos want;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.kind      <= c.kind;
        cmd_if.load_x    <= c.load_x;
        cmd_if.load_y    <= c.load_y;
        cmd_if.accel_x   <= c.accel_x;
        cmd_if.accel_y   <= c.accel_y;
        cmd_if.time_step <= c.time_step;
        do @(posedge i_clk); while (!cmd_if.ready);
        advance_particle(c, want);
        expected_pos_q.push_back(known ? known_pos : want);
    endtask

    // hold the sender until every outstanding item has come back
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (expected_pos_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_particle_cmd noise_cmd();
        t_particle_cmd c;
        c.kind      = 2'($urandom());
        c.load_x    = $urandom();
        c.load_y    = $urandom();
        c.accel_x   = $urandom();
        c.accel_y   = $urandom();
        c.time_step = 16'($urandom());
        return c;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_coord(input logic [ARENA_W-1:0] span);
        if ($urandom_range(0, 7) == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 32'(span));
    endfunction

    function automatic logic signed [POS_W-1:0] pick_accel();
        if ($urandom_range(0, 5) == 0) begin
            return $urandom();
        end
        // mostly within +/-64.0
        return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_dt();
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom());
        end
        return 16'($urandom_range(0, 4096));
    endfunction

    // one load, then a run of accel and step items with some noise mixed in
    task automatic run_scene(inout int sent);
        t_particle_cmd c;
        t_particle_pos none;
        int            ops;
        int            roll;
        none     = '0;
        c        = noise_cmd();
        c.kind   = KIND_LOAD;
        c.load_x = pick_coord(arena_cfg.width);
        c.load_y = pick_coord(arena_cfg.height);
        drive_cmd(c, 1'b0, none);
        sent++;
        ops = $urandom_range(4, 16);
        repeat (ops) begin
            c    = noise_cmd();
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                c.kind    = KIND_ACCEL;
                c.accel_x = pick_accel();
                c.accel_y = pick_accel();
            end else if (roll < 90) begin
                c.kind      = KIND_STEP;
                c.time_step = pick_dt();
            end else if (roll < 95) begin
                c.kind = KIND_UNUSED;
            end else begin
                c.kind = KIND_LOAD;
            end
            drive_cmd(c, 1'b0, none);
            sent++;
        end
    endtask

    function automatic t_dir_row dir_row(input logic [1:0] kind,
                                         input logic signed [POS_W-1:0] lx, ly, ax, ay,
                                         input logic [COEF_BITS-1:0] dt, input logic known,
                                         input logic signed [POS_W-1:0] ex, ey,
                                         input t_hit hx, hy);
        t_dir_row row;
        row.cmd.kind      = kind;
        row.cmd.load_x    = lx;
        row.cmd.load_y    = ly;
        row.cmd.accel_x   = ax;
        row.cmd.accel_y   = ay;
        row.cmd.time_step = dt;
        row.known         = known;
        row.pos.pos_x     = ex;
        row.pos.pos_y     = ey;
        row.pos.hit_x     = hx;
        row.pos.hit_y     = hy;
        return row;
    endfunction

    // directed table; rows with known = 0 go to the predictor
    initial begin
        dir_rows.push_back(dir_row(KIND_UNUSED, 0, 0, 0, 0, 0, 1'b1, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 0,
                                   1'b1, 32'sd655360, 32'sd655360, HIT_LOW, HIT_LOW));
        dir_rows.push_back(dir_row(KIND_LOAD, 32'sd6553600, 32'sd3276800, POS_MIN, POS_MAX,
                                   16'hFFFF, 1'b1, 32'sd6553600, 32'sd3276800,
                                   HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_ACCEL, 0, 0, POS_MAX, POS_MIN, 0,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_ACCEL, POS_MAX, POS_MIN, POS_MAX, POS_MIN, 16'hFFFF,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'hFFFF,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_LOAD, POS_MAX, POS_MIN, 0, 0, 0,
                                   1'b1, POS_MAX, POS_MIN, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_LOAD, POS_MIN, POS_MAX, 0, 0, 0,
                                   1'b1, POS_MIN, POS_MAX, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'h8000,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_UNUSED, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 16'hFFFF,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_LOAD, 32'sd41943040, 32'sd23592960, 0, 0, 0,
                                   1'b1, 32'sd41943040, 32'sd23592960, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_ACCEL, 0, 0, 32'sd65536, -32'sd65536, 0,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_ACCEL, 0, 0, -32'sd131072, 32'sd32768, 0,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'h0444,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'h0444,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_LOAD, 32'sd83558400, 32'sd46858240, 0, 0, 0,
                                   1'b1, 32'sd83558400, 32'sd46858240, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_ACCEL, 0, 0, POS_MIN, POS_MAX, 0,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'h0001,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 16'hFFFF,
                                   1'b0, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_LOAD, 0, 0, POS_MAX, POS_MAX, 16'hFFFF,
                                   1'b1, 0, 0, HIT_NONE, HIT_NONE));
        dir_rows.push_back(dir_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, HIT_NONE, HIT_NONE));
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_off_req && !hold_done) begin
            res_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_particle_pos want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_pos_q.size() == 0) begin
                report_mismatch("pos_x, no item expected", '0, res_if.pos_x);
            end else begin
                want = expected_pos_q.pop_front();
                if (res_if.pos_x !== want.pos_x) begin
                    report_mismatch("pos_x", want.pos_x, res_if.pos_x);
                end
                if (res_if.pos_y !== want.pos_y) begin
                    report_mismatch("pos_y", want.pos_y, res_if.pos_y);
                end
                if (res_if.hit_x !== want.hit_x) begin
                    report_mismatch("hit_x", 32'(want.hit_x), 32'(res_if.hit_x));
                end
                if (res_if.hit_y !== want.hit_y) begin
                    report_mismatch("hit_y", 32'(want.hit_y), 32'(res_if.hit_y));
                end
            end
            result_idx++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** verlet_particle_wall_bounce: FAILED **");
            $finish;
        end
    end

    initial begin
        t_cfg cfg;
        int   sent;
        logic held;
        logic paused;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.kind      = KIND_LOAD;
        cmd_if.load_x    = '0;
        cmd_if.load_y    = '0;
        cmd_if.accel_x   = '0;
        cmd_if.accel_y   = '0;
        cmd_if.time_step = '0;
        hold_off_req     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        held             = 1'b0;
        paused           = 1'b0;
        part_x = 0; part_y = 0; trail_x = 0; trail_y = 0; accel_sum_x = 0; accel_sum_y = 0;
        arena_cfg.radius   = RADIUS_RST;
        arena_cfg.friction = FRICTION_RST;
        arena_cfg.bounce   = BOUNCE_RST;
        arena_cfg.width    = WIDTH_RST;
        arena_cfg.height   = HEIGHT_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            drive_cmd(dir_rows[i].cmd, dir_rows[i].known, dir_rows[i].pos);
        end
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            cfg.radius   = RADIUS_W'($urandom_range(0, 32'(RADIUS_MAX)));
            cfg.friction = 16'($urandom());
            cfg.bounce   = 16'($urandom());
            cfg.width    = ARENA_W'($urandom_range(0, 32'(ARENA_MAX)));
            cfg.height   = ARENA_W'($urandom_range(0, 32'(ARENA_MAX)));
            case (ph)
                1: begin
                    cfg.radius   = '0;
                    cfg.friction = 16'hFFFF;
                    cfg.bounce   = 16'hFFFF;
                    cfg.width    = ARENA_MAX;
                    cfg.height   = ARENA_MAX;
                end
                2: begin
                    // radius larger than the arena: clamps go negative
                    cfg.radius   = RADIUS_MAX;
                    cfg.friction = '0;
                    cfg.bounce   = '0;
                    cfg.width    = '0;
                    cfg.height   = '0;
                end
                4: begin
                    cfg.radius   = RADIUS_RST;
                    cfg.friction = FRICTION_RST;
                    cfg.bounce   = BOUNCE_RST;
                    cfg.width    = WIDTH_RST;
                    cfg.height   = HEIGHT_RST;
                end
                default: begin
                end
            endcase
            set_config(cfg);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (ph == 3 && !held && sent >= 40) begin
                    hold_off_req <= 1'b1;
                    held = 1'b1;
                end
                if (ph == 4 && !paused && sent >= 60) begin
                    drain_results();
                    paused = 1'b1;
                end
                run_scene(sent);
            end
            drain_results();
        end

        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** verlet_particle_wall_bounce: PASSED **");
        end else begin
            $display("** verlet_particle_wall_bounce: FAILED **");
        end
        $finish;
    end

endmodule
